// ===== rtl/core/multiprecision_multiply_top_macros.svh =====
// Assertion macros shared by the multiprecision multiplier RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef MULTIPRECISION_MULTIPLY_TOP_MACROS_SVH
`define MULTIPRECISION_MULTIPLY_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define MPM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPM_ASSERT(lbl, cond, msg)
`define MPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mpm_pkg.sv =====
// Package for the multiprecision multiplier: sizes, payload structs,
// operation codes, sequencer states and the multiply-add unit interface.
`timescale 1ns / 1ps

package mpm_pkg;

  localparam int LIMB_W     = 64;
  localparam int HALF_W     = LIMB_W / 2;
  localparam int MAX_LIMBS  = 32;
  localparam int IDX_W      = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int LEN_W      = $clog2(MAX_LIMBS + 1);
  localparam int PROD_DEPTH = 2 * MAX_LIMBS;
  localparam int PIDX_W     = $clog2(PROD_DEPTH);
  localparam int CNT_W      = $clog2(PROD_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LIMB_W-1:0] limb;
  } in_item_t;

  typedef struct packed {
    logic [LIMB_W-1:0] product_limb;
    logic              last_limb;
    logic              overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_CARRY,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [LIMB_W-1:0] x;
    logic [LIMB_W-1:0] y;
    logic [LIMB_W-1:0] c1;
    logic [LIMB_W-1:0] c2;
  } mac_req_t;

  typedef struct packed {
    logic              done;
    logic [LIMB_W-1:0] hi;
    logic [LIMB_W-1:0] lo;
  } mac_rsp_t;

endpackage

// ===== rtl/core/mpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpm_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mpm_mac.sv =====
// Iterative 64x64 multiply with two 64-bit addends, one 32x32 partial product per cycle.
// Depends on mpm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multiprecision_multiply_top_macros.svh"

module mpm_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  mpm_pkg::mac_req_t req,
  output mpm_pkg::mac_rsp_t rsp
);
  import mpm_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [2:0]          step_r;
  logic [1:0]          pp_sel_r;
  logic [LIMB_W-1:0]   x_r;
  logic [LIMB_W-1:0]   y_r;
  logic [LIMB_W-1:0]   pp_r;
  logic [2*LIMB_W-1:0] acc_r;

  logic [HALF_W-1:0]   x_half;
  logic [HALF_W-1:0]   y_half;
  logic [LIMB_W-1:0]   pp_nxt;
  logic [2*LIMB_W-1:0] pp_sh;
  logic [LIMB_W:0]     addend_sum;

  // Pair order: lo*lo, lo*hi, hi*lo, hi*hi
  assign x_half = step_r[1] ? x_r[LIMB_W-1:HALF_W] : x_r[HALF_W-1:0];
  assign y_half = step_r[0] ? y_r[LIMB_W-1:HALF_W] : y_r[HALF_W-1:0];
  assign pp_nxt = LIMB_W'(x_half) * LIMB_W'(y_half);
  assign addend_sum = {1'b0, req.c1} + {1'b0, req.c2};

  always_comb begin
    case (pp_sel_r)
      2'd0:    pp_sh = {{LIMB_W{1'b0}}, pp_r};
      2'd3:    pp_sh = {pp_r, {LIMB_W{1'b0}}};
      default: pp_sh = {{HALF_W{1'b0}}, pp_r, {HALF_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      acc_r <= {{(LIMB_W - 1){1'b0}}, addend_sum};
    end else if (busy_r) begin
      if (step_r != 3'd4) begin
        pp_r     <= pp_nxt;
        pp_sel_r <= step_r[1:0];
      end
      // fold the product from the previous step
      if (step_r != 3'd0) begin
        acc_r <= acc_r + pp_sh;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.hi   = acc_r[2*LIMB_W-1:LIMB_W];
  assign rsp.lo   = acc_r[LIMB_W-1:0];

  `MPM_ASSERT_IMPL(a_mac_start_idle, req.start, !busy_r, "mac started while busy")
  `MPM_ASSERT_NEXT(a_mac_done_pulse, done_r, !done_r && !busy_r, "mac done not a pulse")

endmodule

// ===== rtl/core/multiprecision_multiply_top.sv =====
// Multiprecision multiplier top: operand and product stores, row sequencer, output register.
// Depends on mpm_pkg, mpm_ram, mpm_mac and the assertion macro header.
`timescale 1ns / 1ps
`include "multiprecision_multiply_top_macros.svh"

// Unsigned schoolbook multiplier over 64-bit limbs, least significant limb first.
// Load requests (operation 0 for a, 1 for b) each append a limb;
// limbs beyond 32 per operand are dropped and reported through overflowed on the next
// product. A start request (operation 2) keeps in_stall high until the whole product has
// been delivered: every limb pair goes through one shared 64x64 multiply-add unit that
// builds the 128-bit result from four 32x32 partial products, with operand and product
// store reads, and each row then writes its carry. The product is sent as
// a_length + b_length limbs (one zero limb when both operands are empty), last_limb
// marking the top limb. The product store needs no clearing pass: row 0 adds zero in
// place of the stored limb, and an empty operand sends zeros without reading the store.
// Operand counts and the overflow flag clear once the last product limb is taken.
module multiprecision_multiply_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mpm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mpm_pkg::out_item_t out_data
);
  import mpm_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [LEN_W-1:0]  a_len_r;
  logic [LEN_W-1:0]  b_len_r;
  logic              ovf_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [PIDX_W-1:0] k_r;
  logic [CNT_W-1:0]  total_r;
  logic              zero_r;
  logic [LIMB_W-1:0] carry_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_accept;
  logic              out_accept;
  logic              a_full;
  logic              b_full;
  logic              row_end;
  logic              a_end;
  logic              k_last;
  logic [CNT_W-1:0]  len_sum;
  logic [PIDX_W-1:0] sum_ij;
  logic [PIDX_W-1:0] sum_ib;

  logic              a_we;
  logic              b_we;
  logic              prod_we;
  logic [PIDX_W-1:0] prod_waddr;
  logic [LIMB_W-1:0] prod_wdata;
  logic [PIDX_W-1:0] prod_raddr;
  logic [LIMB_W-1:0] a_rdata;
  logic [LIMB_W-1:0] b_rdata;
  logic [LIMB_W-1:0] prod_rdata;

  mac_req_t          mac_req;
  mac_rsp_t          mac_rsp;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  assign a_full  = (a_len_r >= LEN_W'(MAX_LIMBS));
  assign b_full  = (b_len_r >= LEN_W'(MAX_LIMBS));
  assign row_end = ((LEN_W'(j_r) + LEN_W'(1)) == b_len_r);
  assign a_end   = ((LEN_W'(i_r) + LEN_W'(1)) == a_len_r);
  assign k_last  = ((CNT_W'(k_r) + CNT_W'(1)) == total_r);
  assign len_sum = CNT_W'(a_len_r) + CNT_W'(b_len_r);
  assign sum_ij  = PIDX_W'(i_r) + PIDX_W'(j_r);
  assign sum_ib  = PIDX_W'(i_r) + PIDX_W'(b_len_r);
  assign prod_raddr = (state_r == ST_RD) ? sum_ij : k_r;

  mpm_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_len_r[IDX_W-1:0]),
    .wdata (in_data.limb),
    .raddr (i_r),
    .rdata (a_rdata)
  );

  mpm_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_len_r[IDX_W-1:0]),
    .wdata (in_data.limb),
    .raddr (j_r),
    .rdata (b_rdata)
  );

  mpm_ram #(.WIDTH(LIMB_W), .DEPTH(PROD_DEPTH)) u_prod_ram (
    .clk   (clk),
    .we    (prod_we),
    .waddr (prod_waddr),
    .wdata (prod_wdata),
    .raddr (prod_raddr),
    .rdata (prod_rdata)
  );

  mpm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    prod_we       = 1'b0;
    prod_waddr    = sum_ij;
    prod_wdata    = mac_rsp.lo;
    mac_req.start = 1'b0;
    mac_req.x     = a_rdata;
    mac_req.y     = b_rdata;
    // first row starts from an empty product
    mac_req.c1    = (i_r == '0) ? '0 : prod_rdata;
    mac_req.c2    = carry_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data.operation)
            OP_LOAD_A: a_we = !a_full;
            OP_LOAD_B: b_we = !b_full;
            OP_START: begin
              state_nxt = (a_len_r == '0 || b_len_r == '0) ? ST_EMIT_RD : ST_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD:     state_nxt = ST_MAC_GO;
      ST_MAC_GO: begin
        mac_req.start = 1'b1;
        state_nxt     = ST_MAC_WAIT;
      end
      ST_MAC_WAIT: begin
        if (mac_rsp.done) begin
          prod_we   = 1'b1;
          state_nxt = row_end ? ST_CARRY : ST_RD;
        end
      end
      ST_CARRY: begin
        prod_we    = 1'b1;
        prod_waddr = sum_ib;
        prod_wdata = carry_r;
        state_nxt  = a_end ? ST_EMIT_RD : ST_RD;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_accept) begin
          state_nxt = out_data_r.last_limb ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_len_r     <= '0;
      b_len_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_accept) begin
        case (in_data.operation)
          OP_LOAD_A: begin
            if (a_full) begin
              ovf_r <= 1'b1;
            end else begin
              a_len_r <= a_len_r + LEN_W'(1);
            end
          end
          OP_LOAD_B: begin
            if (b_full) begin
              ovf_r <= 1'b1;
            end else begin
              b_len_r <= b_len_r + LEN_W'(1);
            end
          end
          default: ovf_r <= ovf_r;
        endcase
      end
      if (state_r == ST_EMIT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
        // drop the operands once the top limb is taken
        if (out_data_r.last_limb) begin
          a_len_r <= '0;
          b_len_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        i_r     <= '0;
        j_r     <= '0;
        k_r     <= '0;
        carry_r <= '0;
        total_r <= (len_sum == '0) ? CNT_W'(1) : len_sum;
        zero_r  <= (a_len_r == '0 || b_len_r == '0);
      end
      ST_MAC_WAIT: begin
        if (mac_rsp.done) begin
          carry_r <= mac_rsp.hi;
          j_r     <= row_end ? '0 : j_r + IDX_W'(1);
        end
      end
      ST_CARRY: begin
        carry_r <= '0;
        i_r     <= i_r + IDX_W'(1);
      end
      ST_EMIT_LD: begin
        out_data_r.product_limb <= zero_r ? '0 : prod_rdata;
        out_data_r.last_limb    <= k_last;
        out_data_r.overflowed   <= ovf_r;
      end
      ST_EMIT_HOLD: begin
        if (out_accept) begin
          k_r <= k_r + PIDX_W'(1);
        end
      end
      default: carry_r <= carry_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MPM_ASSERT_IMPL(a_out_only_in_hold, out_valid_r, state_r == ST_EMIT_HOLD,
                   "result shown outside the hold state")
  `MPM_ASSERT_IMPL(a_prod_wr_range, prod_we, CNT_W'(prod_waddr) < total_r,
                   "product write beyond product length")
  `MPM_ASSERT_NEXT(a_out_advance, out_accept && !out_data_r.last_limb,
                   state_r == ST_EMIT_RD, "no next limb read after a taken limb")
  `MPM_ASSERT_NEXT(a_clear_after_last, out_accept && out_data_r.last_limb,
                   a_len_r == '0 && b_len_r == '0 && !ovf_r && state_r == ST_IDLE,
                   "operand state not cleared after the last limb")

endmodule
